@@ rtl/isa_pkg.sv @@
// Package for the inverse smoothstep age block.
// Holds the sequencer state type, register indexes, widths and the divider request struct.
// No dependencies.
`default_nettype none

package isa_pkg;

    localparam int NEWTON_STEPS_DEF = 8;

    localparam int SCALE_W = 32;
    localparam int AGE_W   = 17;
    localparam int IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_INITIAL_SCALE = 1'b0;
    localparam logic [IDX_W-1:0] REG_FINAL_SCALE   = 1'b1;

    localparam logic [AGE_W-1:0] ONE_Q16 = 17'd65536;

    // Divider: 33-bit divisor and remainder, 34-bit quotient register.
    localparam int DIV_RW = 33;
    localparam int DIV_QW = 34;
    localparam int DIV_CW = 6;

    localparam logic [DIV_CW-1:0] DIV_STEPS_TARGET = 6'd16;
    localparam logic [DIV_CW-1:0] DIV_STEPS_NEWTON = 6'd34;

    typedef struct packed {
        logic              start;
        logic [DIV_RW-1:0] rem;
        logic [DIV_QW-1:0] quo;
        logic [DIV_RW-1:0] den;
        logic [DIV_CW-1:0] steps;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV_T,
        S_SQ,
        S_CUBE,
        S_SLOPE,
        S_CHECK,
        S_DIV_N,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/isa_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses the request struct from isa_pkg.
`default_nettype none

module isa_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire isa_pkg::t_div_req       i_req,
    output logic                         o_done,
    output logic [isa_pkg::DIV_QW-1:0]   o_quo
);
    import isa_pkg::*;

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_RW-1:0] r_rem;
    logic [DIV_QW-1:0] r_quo;
    logic [DIV_RW-1:0] r_den;

    logic [DIV_RW:0]   rem_sh;
    logic [DIV_RW+1:0] diff;

    assign rem_sh = {r_rem, r_quo[DIV_QW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_quo <= i_req.quo;
            r_den <= i_req.den;
        end else if (r_busy && (r_cnt != '0)) begin
            if (!diff[DIV_RW+1]) begin
                r_rem <= diff[DIV_RW-1:0];
                r_quo <= {r_quo[DIV_QW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DIV_RW-1:0];
                r_quo <= {r_quo[DIV_QW-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/inverse_smoothstep_age.sv @@
// A word runs through prep, the target divide if needed and up to NEWTON_STEPS Newton steps;
// a zero span goes straight from prep to done.
// Throughput: one word at a time, the next one accepted in the cycle after the result is loaded;
// each step runs the multiplies and the check, then the serial divider.
// Reset: synchronous, active low; clears the sequencer and output valid and loads
// initial_scale = 0 and final_scale = 1.0. Depends on isa_pkg and isa_div.
`default_nettype none

module inverse_smoothstep_age #(
    parameter int NEWTON_STEPS = isa_pkg::NEWTON_STEPS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [isa_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [isa_pkg::SCALE_W-1:0]  i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [isa_pkg::SCALE_W-1:0] i_scale,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [isa_pkg::AGE_W-1:0]         o_age
);
    import isa_pkg::*;

    localparam int STEP_W = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;

    t_state r_state, n_state;

    logic signed [SCALE_W-1:0] r_initial;
    logic signed [SCALE_W-1:0] r_final;
    logic signed [SCALE_W:0]   r_span;
    logic signed [SCALE_W:0]   r_off;
    logic [AGE_W-1:0]          r_t;
    logic [AGE_W-1:0]          r_a;
    logic signed [18:0]        r_f;
    logic [35:0]               r_prod;
    logic [STEP_W-1:0]         r_step;
    logic                      r_out_valid;
    logic [AGE_W-1:0]          r_age;

    logic [17:0]       mul_a, mul_b;
    logic              mul_en;
    t_div_req          div_req;
    logic              div_done;
    logic [DIV_QW-1:0] div_quo;

    logic              off_neg, span_neg;
    logic [SCALE_W:0]  off_abs, span_abs;
    logic              t_zero, t_one;
    logic [38:0]       df_full;
    logic [19:0]       df;
    logic              f_neg;
    logic [17:0]       f_abs;
    logic [35:0]       a_ext, q_ext, a_sum;
    logic [AGE_W-1:0]  a_next;
    logic              out_free;
    logic              last_step;

    assign off_neg  = r_off[SCALE_W];
    assign span_neg = r_span[SCALE_W];
    assign off_abs  = off_neg ? -r_off : r_off;
    assign span_abs = span_neg ? -r_span : r_span;
    assign t_zero   = (r_off == '0) || (off_neg != span_neg);
    assign t_one    = off_abs >= span_abs;

    assign df_full  = {1'b0, r_prod, 2'b00} + {2'b00, r_prod, 1'b0};
    assign df       = df_full[35:16];

    assign f_neg    = r_f[18];
    assign f_abs    = f_neg ? 18'(-r_f) : 18'(r_f);

    assign a_ext    = 36'(r_a);
    assign q_ext    = 36'(div_quo);
    assign a_sum    = f_neg ? (a_ext + q_ext) : (a_ext - q_ext);
    assign a_next   = a_sum[35] ? '0 :
                      (a_sum > 36'(ONE_Q16)) ? ONE_Q16 : a_sum[AGE_W-1:0];

    assign out_free  = !r_out_valid || i_ready;
    assign last_step = (r_step == STEP_W'(NEWTON_STEPS - 1));

    isa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_span == '0) begin
                    n_state = S_DONE;
                end else if (t_zero || t_one) begin
                    n_state = S_SQ;
                end else begin
                    n_state = S_DIV_T;
                end
            end
            S_DIV_T: begin
                if (div_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:    n_state = S_CUBE;
            S_CUBE:  n_state = S_SLOPE;
            S_SLOPE: n_state = S_CHECK;
            S_CHECK: begin
                n_state = (df == '0) ? S_DONE : S_DIV_N;
            end
            S_DIV_N: begin
                if (div_done) begin
                    n_state = last_step ? S_DONE : S_SQ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_req = '0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_PREP: begin
                div_req.start = (r_span != '0) && !t_zero && !t_one;
                div_req.rem   = off_abs;
                div_req.quo   = '0;
                div_req.den   = span_abs;
                div_req.steps = DIV_STEPS_TARGET;
            end
            S_SQ: begin
                mul_en = 1'b1;
                mul_a  = 18'(r_a);
                mul_b  = 18'(r_a);
            end
            S_CUBE: begin
                mul_en = 1'b1;
                mul_a  = 18'(r_prod[32:16]);
                mul_b  = 18'd196608 - {r_a, 1'b0};
            end
            S_SLOPE: begin
                mul_en = 1'b1;
                mul_a  = 18'(r_a);
                mul_b  = 18'(ONE_Q16) - 18'(r_a);
            end
            S_CHECK: begin
                div_req.start = (df != '0);
                div_req.rem   = '0;
                div_req.quo   = {f_abs[DIV_QW-17:0], 16'h0000};
                div_req.den   = DIV_RW'(df);
                div_req.steps = DIV_STEPS_NEWTON;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_initial   <= '0;
            r_final     <= SCALE_W'(ONE_Q16);
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_INITIAL_SCALE: r_initial <= i_cfg_data;
                    REG_FINAL_SCALE:   r_final   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (r_state)
            S_IDLE: begin
                r_span <= {r_final[SCALE_W-1], r_final} - {r_initial[SCALE_W-1], r_initial};
                r_off  <= {i_scale[SCALE_W-1], i_scale} - {r_initial[SCALE_W-1], r_initial};
            end
            S_PREP: begin
                r_step <= '0;
                if (r_span == '0) begin
                    r_a <= '0;
                end else if (t_zero) begin
                    r_t <= '0;
                    r_a <= '0;
                end else if (t_one) begin
                    r_t <= ONE_Q16;
                    r_a <= ONE_Q16;
                end
            end
            S_DIV_T: begin
                if (div_done) begin
                    r_t <= {1'b0, div_quo[15:0]};
                    r_a <= {1'b0, div_quo[15:0]};
                end
            end
            S_SLOPE: begin
                r_f <= $signed({1'b0, r_prod[33:16]}) - $signed({2'b00, r_t});
            end
            S_DIV_N: begin
                if (div_done) begin
                    r_a    <= a_next;
                    r_step <= r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_age <= r_a;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_age   = r_age;

endmodule

`default_nettype wire
